// ----- rtl/lprl_pkg.sv -----
package lprl_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [3:0]  slot;
    logic [31:0] route_prefix;
    logic [31:0] route_mask;
    logic [31:0] route_gateway;
    logic [3:0]  route_port;
    logic        route_valid;
    logic [31:0] lookup_addr;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [31:0] hop_addr;
    logic [3:0]  out_port;
    logic [31:0] matched_mask;
  } rsp_t;

  typedef struct packed {
    logic [31:0] prefix;
    logic [31:0] mask;
    logic [31:0] gateway;
    logic [3:0]  port;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_item;
    logic wr_en;
    logic rd_en;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic idx_last;
  } dp_sts_t;

endpackage

// ----- rtl/lprl_ctrl.sv -----
module lprl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_cmd,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output lprl_pkg::dp_cmd_t dp_cmd,
  input  lprl_pkg::dp_sts_t dp_sts
);

  lprl_pkg::state_t state, state_next;
  logic             out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lprl_pkg::ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (dp_cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign out_busy = rsp_valid && !rsp_ready;

  always_comb begin
    state_next = state;
    dp_cmd     = '0;
    req_ready  = 1'b0;
    case (state)
      lprl_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          dp_cmd.load_item = 1'b1;
          state_next = (req_cmd == lprl_pkg::CMD_LOOKUP) ? lprl_pkg::ST_SCAN
                                                         : lprl_pkg::ST_WRITE;
        end
      end
      lprl_pkg::ST_WRITE: begin
        dp_cmd.wr_en = 1'b1;
        state_next   = lprl_pkg::ST_DONE;
      end
      lprl_pkg::ST_SCAN: begin
        dp_cmd.rd_en = 1'b1;
        if (dp_sts.idx_last) begin
          state_next = lprl_pkg::ST_DRAIN;
        end
      end
      lprl_pkg::ST_DRAIN: begin
        // last slot is compared this cycle
        state_next = lprl_pkg::ST_DONE;
      end
      lprl_pkg::ST_DONE: begin
        if (!out_busy) begin
          dp_cmd.load_out = 1'b1;
          state_next      = lprl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lprl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/lprl_dp.sv -----
module lprl_dp (
  input  logic              clk,
  input  logic              rst,
  input  lprl_pkg::req_t    req,
  output lprl_pkg::rsp_t    rsp,
  input  lprl_pkg::dp_cmd_t dp_cmd,
  output lprl_pkg::dp_sts_t dp_sts
);

  lprl_pkg::req_t                 item;
  lprl_pkg::entry_t               mem [lprl_pkg::ENTRIES];
  logic [lprl_pkg::ENTRIES-1:0]   vbits;
  logic [lprl_pkg::IDX_W-1:0]     idx;
  logic [lprl_pkg::IDX_W-1:0]     waddr;
  logic [31:0]                    slot_wide;
  logic                           slot_ok;
  lprl_pkg::entry_t               rd_entry;
  logic                           rd_vbit;
  logic                           cmp_vld;
  logic                           hit;
  logic [31:0]                    best_mask;
  logic [31:0]                    best_gw;
  logic [3:0]                     best_port;
  logic                           match;
  logic                           better;
  lprl_pkg::rsp_t                 result;

  assign slot_wide = {28'd0, item.slot};
  assign slot_ok   = slot_wide < lprl_pkg::ENTRIES;
  assign waddr     = slot_wide[lprl_pkg::IDX_W-1:0];

  assign dp_sts.idx_last = (idx == lprl_pkg::IDX_W'(lprl_pkg::ENTRIES - 1));

  always_ff @(posedge clk) begin
    if (dp_cmd.load_item) begin
      item <= req;
    end
    if (dp_cmd.wr_en && slot_ok && item.route_valid) begin
      mem[waddr] <= '{prefix:  item.route_prefix,
                      mask:    item.route_mask,
                      gateway: item.route_gateway,
                      port:    item.route_port};
    end
    if (dp_cmd.rd_en) begin
      rd_entry <= mem[idx];
      rd_vbit  <= vbits[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vbits   <= '0;
      idx     <= '0;
      cmp_vld <= 1'b0;
      hit     <= 1'b0;
    end else begin
      if (dp_cmd.wr_en && slot_ok) begin
        vbits[waddr] <= item.route_valid;
      end
      if (dp_cmd.load_item) begin
        idx <= '0;
      end else if (dp_cmd.rd_en && !dp_sts.idx_last) begin
        idx <= idx + 1'b1;
      end
      cmp_vld <= dp_cmd.rd_en;
      if (dp_cmd.load_item) begin
        hit <= 1'b0;
      end else if (cmp_vld && match && better) begin
        hit <= 1'b1;
      end
    end
  end

  // strict compare keeps the lower slot on equal masks
  assign match  = rd_vbit &&
                  ((item.lookup_addr & rd_entry.mask) == (rd_entry.prefix & rd_entry.mask));
  assign better = !hit || (rd_entry.mask > best_mask);

  always_ff @(posedge clk) begin
    if (cmp_vld && match && better) begin
      best_mask <= rd_entry.mask;
      best_gw   <= rd_entry.gateway;
      best_port <= rd_entry.port;
    end
  end

  always_comb begin
    result = '0;
    if (hit) begin
      result.found        = 1'b1;
      result.hop_addr     = (best_gw != 32'd0) ? best_gw : item.lookup_addr;
      result.out_port     = best_port;
      result.matched_mask = best_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load_out) begin
      rsp <= result;
    end
  end

endmodule

// ----- rtl/longest_prefix_route_lookup.sv -----
// channel | direction | handshake            | payload
// req     | in        | req_valid, req_ready | lprl_pkg::req_t
// rsp     | out       | rsp_valid, rsp_ready | lprl_pkg::rsp_t
//
// One item at a time; req_ready is high only while the block is idle.
// A write passes through WRITE and DONE to its result; a lookup through SCAN,
// DRAIN and DONE, the scan reading one table slot per cycle over all ENTRIES.
// Synchronous reset clears all valid bits; table contents are kept.
// A stalled result holds in the output register; the next item waits behind it.
module longest_prefix_route_lookup (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  lprl_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output lprl_pkg::rsp_t rsp
);

  lprl_pkg::dp_cmd_t dp_cmd;
  lprl_pkg::dp_sts_t dp_sts;

  lprl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_cmd   (req.cmd),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .dp_cmd    (dp_cmd),
    .dp_sts    (dp_sts)
  );

  lprl_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .rsp    (rsp),
    .dp_cmd (dp_cmd),
    .dp_sts (dp_sts)
  );

endmodule

// ----- rtl/lprl_checker.sv -----
module lprl_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input lprl_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input lprl_pkg::rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.found |->
      rsp.hop_addr == 32'd0 && rsp.out_port == 4'd0 && rsp.matched_mask == 32'd0)
    else $error("miss result carries nonzero fields");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second item taken while busy");

  a_write_rsp: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req.cmd == lprl_pkg::CMD_WRITE && !rsp_valid
      |-> ##3 rsp_valid && !rsp.found)
    else $error("write item did not give an empty result in time");

  a_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid && req_ready)
    else $error("block not idle after reset");

endmodule

bind longest_prefix_route_lookup lprl_checker u_lprl_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
